>>> design/multi_queue_action_fifo_assert.svh
// assertion helpers, sampled on clk_i and disabled during reset
`ifndef MULTI_QUEUE_ACTION_FIFO_ASSERT_SVH
`define MULTI_QUEUE_ACTION_FIFO_ASSERT_SVH

// same-cycle implication
`define MQAF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQAF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mqaf_pkg.sv
package mqaf_pkg;

  localparam int CMD_BITS    = 3;
  localparam int SEL_BITS    = 2;
  localparam int ACTION_BITS = 8;
  localparam int ARG_BITS    = 32;
  localparam int TIME_BITS   = 32;
  localparam int KIND_BITS   = 2;

  localparam int IN_TDATA_BITS  = 80;
  localparam int OUT_TDATA_BITS = 80;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD       = 3'd0,
    CMD_NEXT      = 3'd1,
    CMD_RUN       = 3'd2,
    CMD_SET_ERROR = 3'd3,
    CMD_RESET_ONE = 3'd4,
    CMD_RESET_ALL = 3'd5
  } cmd_e;

  typedef enum logic [KIND_BITS-1:0] {
    EV_STATUS = 2'd0,
    EV_START  = 2'd1,
    EV_RUN    = 2'd2
  } kind_e;

  typedef struct packed {
    logic empty;
    logic full;
    logic rd_next_empty;
  } qflags_t;

endpackage

>>> design/mqaf_store.sv
module mqaf_store #(
  parameter int DEPTH = 36,
  parameter int WIDTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mqaf_qunit.sv
module mqaf_qunit #(
  parameter int SLOTS = 9,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              [IW-1:0] wr_idx_i,
  input  logic              [IW-1:0] rd_idx_i,
  output logic              [IW-1:0] wr_next_o,
  output logic              [IW-1:0] rd_next_o,
  output mqaf_pkg::qflags_t          flags_o
);

  localparam logic [IW-1:0] LastSlot = IW'(SLOTS - 1);

  // circular increment over the slots of one queue
  assign wr_next_o = (wr_idx_i == LastSlot) ? '0 : wr_idx_i + 1'b1;
  assign rd_next_o = (rd_idx_i == LastSlot) ? '0 : rd_idx_i + 1'b1;

  assign flags_o.empty         = (wr_idx_i == rd_idx_i);
  assign flags_o.full          = (wr_next_o == rd_idx_i);
  assign flags_o.rd_next_empty = (rd_next_o == wr_idx_i);

endmodule

>>> design/multi_queue_action_fifo.sv
// Multi-queue action FIFO. NUM_QUEUES circular queues of (action code, argument) pairs,
// each QUEUE_DEPTH entries deep, share one entry memory with one write and one registered
// read port. One command is taken at a time: s_axis_tready_o is high only while the
// sequencer is idle. Add, next, set_error, reset one, reset all and unused codes give one
// beat through the steps accept, execute, memory read and load of the output register. Run
// skips empty queues one per cycle and, for each non-empty queue, goes through the memory
// read and emit steps, where an untaken beat in the output register can hold it; with
// all queues empty it gives no beat. A new beat that finds the output register still
// holding an untaken beat holds the sequencer in its emit step for as long as that lasts.
// The output register lets the next command be taken while the last beat still waits
// downstream. tlast marks the last beat of a command.
`include "multi_queue_action_fifo_assert.svh"

module multi_queue_action_fifo #(
  parameter int NUM_QUEUES  = mqaf_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqaf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // cmd, queue_sel, action_code, action_arg, now_time, error_value
  input  logic [mqaf_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // event_queue, head_action, head_arg, head_start_time, error_flag, accepted
  output logic [mqaf_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata_o,
  // event_kind
  output logic [mqaf_pkg::KIND_BITS-1:0]        m_axis_tuser_o,
  output logic                                  m_axis_tlast_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i
);

  localparam int Slots      = QUEUE_DEPTH + 1;
  localparam int IW         = $clog2(Slots);
  localparam int QIW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int MemDepth   = NUM_QUEUES * Slots;
  localparam int AW         = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int ActBits    = mqaf_pkg::ACTION_BITS;
  localparam int ArgBits    = mqaf_pkg::ARG_BITS;
  localparam int TimeBits   = mqaf_pkg::TIME_BITS;
  localparam int SelBits    = mqaf_pkg::SEL_BITS;
  localparam int EntryBits  = ActBits + ArgBits;
  localparam int OutUsed    = SelBits + ActBits + ArgBits + TimeBits + 2;
  localparam logic [QIW-1:0] LastQueue = QIW'(NUM_QUEUES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e state_q;

  // queue state
  logic [IW-1:0]       wr_idx_q [NUM_QUEUES];
  logic [IW-1:0]       rd_idx_q [NUM_QUEUES];
  logic [TimeBits-1:0] start_q  [NUM_QUEUES];
  logic                err_q    [NUM_QUEUES];

  // command being worked on
  mqaf_pkg::cmd_e      cmd_q;
  logic [SelBits-1:0]  sel_q;
  logic [ActBits-1:0]  code_q;
  logic [ArgBits-1:0]  arg_q;
  logic [TimeBits-1:0] now_q;
  logic                errv_q;
  logic [QIW-1:0]      scan_q;

  // pending beat
  mqaf_pkg::kind_e     kind_q;
  logic                qv_q;
  logic                hv_q;
  logic                acc_q;
  logic                last_q;

  // output register
  logic                ov_q;
  mqaf_pkg::kind_e     o_kind_q;
  logic [SelBits-1:0]  o_queue_q;
  logic [ActBits-1:0]  o_action_q;
  logic [ArgBits-1:0]  o_arg_q;
  logic [TimeBits-1:0] o_start_q;
  logic                o_err_q;
  logic                o_acc_q;
  logic                o_last_q;

  logic [QIW-1:0]        cur_idx;
  logic                  sel_valid;
  logic [IW-1:0]         wr_cur;
  logic [IW-1:0]         rd_cur;
  logic [IW-1:0]         wr_next;
  logic [IW-1:0]         rd_next;
  mqaf_pkg::qflags_t     qflags;
  logic [NUM_QUEUES-1:0] ne_mask;
  logic [NUM_QUEUES-1:0] ne_from_scan;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [EntryBits-1:0]  mem_rdata;
  logic                  head_on;
  logic                  out_free;
  logic                  out_load;
  mqaf_pkg::kind_e       exec_kind;
  logic                  exec_qv;
  logic                  exec_hv;
  logic                  exec_acc;

  assign cur_idx   = (cmd_q == mqaf_pkg::CMD_RUN) ? scan_q : QIW'(sel_q);
  assign sel_valid = (int'(sel_q) < NUM_QUEUES);
  assign wr_cur    = wr_idx_q[cur_idx];
  assign rd_cur    = rd_idx_q[cur_idx];

  mqaf_qunit #(
    .SLOTS(Slots)
  ) u_qunit (
    .wr_idx_i (wr_cur),
    .rd_idx_i (rd_cur),
    .wr_next_o(wr_next),
    .rd_next_o(rd_next),
    .flags_o  (qflags)
  );

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      ne_mask[i] = (wr_idx_q[i] != rd_idx_q[i]);
    end
  end

  assign ne_from_scan = ne_mask >> scan_q;

  // beat fields decided by the execute step
  always_comb begin
    exec_kind = mqaf_pkg::EV_STATUS;
    exec_qv   = sel_valid;
    exec_hv   = !qflags.empty;
    exec_acc  = 1'b0;
    if (cmd_q == mqaf_pkg::CMD_RESET_ALL) begin
      exec_qv = 1'b0;
    end else if (sel_valid) begin
      case (cmd_q)
        mqaf_pkg::CMD_ADD: begin
          if (!qflags.full) begin
            exec_acc = 1'b1;
            exec_hv  = 1'b1;
            if (qflags.empty) begin
              exec_kind = mqaf_pkg::EV_START;
            end
          end
        end
        mqaf_pkg::CMD_NEXT: begin
          if (!qflags.empty) begin
            exec_hv = !qflags.rd_next_empty;
            if (!qflags.rd_next_empty) begin
              exec_kind = mqaf_pkg::EV_START;
            end
          end
        end
        mqaf_pkg::CMD_RESET_ONE: begin
          exec_hv = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_we    = (state_q == ST_EXEC) && (cmd_q == mqaf_pkg::CMD_ADD) && sel_valid &&
                     !qflags.full;
  assign mem_waddr = AW'(int'(cur_idx) * Slots + int'(wr_cur));
  assign mem_raddr = AW'(int'(cur_idx) * Slots + int'(rd_cur));

  mqaf_store #(
    .DEPTH(MemDepth),
    .WIDTH(EntryBits)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i({code_q, arg_q}),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign head_on  = qv_q && hv_q;
  assign out_free = !ov_q || m_axis_tready_i;
  assign out_load = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wr_idx_q[i] <= '0;
        rd_idx_q[i] <= '0;
        start_q[i]  <= '0;
        err_q[i]    <= 1'b0;
      end
      cmd_q      <= mqaf_pkg::CMD_ADD;
      sel_q      <= '0;
      code_q     <= '0;
      arg_q      <= '0;
      now_q      <= '0;
      errv_q     <= 1'b0;
      scan_q     <= '0;
      kind_q     <= mqaf_pkg::EV_STATUS;
      qv_q       <= 1'b0;
      hv_q       <= 1'b0;
      acc_q      <= 1'b0;
      last_q     <= 1'b0;
      ov_q       <= 1'b0;
      o_kind_q   <= mqaf_pkg::EV_STATUS;
      o_queue_q  <= '0;
      o_action_q <= '0;
      o_arg_q    <= '0;
      o_start_q  <= '0;
      o_err_q    <= 1'b0;
      o_acc_q    <= 1'b0;
      o_last_q   <= 1'b0;
    end else begin
      if (m_axis_tready_i && !out_load) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q  <= mqaf_pkg::cmd_e'(s_axis_tdata_i[2:0]);
            sel_q  <= s_axis_tdata_i[4:3];
            code_q <= s_axis_tdata_i[12:5];
            arg_q  <= s_axis_tdata_i[44:13];
            now_q  <= s_axis_tdata_i[76:45];
            errv_q <= s_axis_tdata_i[77];
            scan_q <= '0;
            if (mqaf_pkg::cmd_e'(s_axis_tdata_i[2:0]) == mqaf_pkg::CMD_RUN) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          kind_q  <= exec_kind;
          qv_q    <= exec_qv;
          hv_q    <= exec_hv;
          acc_q   <= exec_acc;
          last_q  <= 1'b1;
          state_q <= ST_READ;
          if (cmd_q == mqaf_pkg::CMD_RESET_ALL) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
              wr_idx_q[i] <= '0;
              rd_idx_q[i] <= '0;
              err_q[i]    <= 1'b0;
            end
          end else if (sel_valid) begin
            case (cmd_q)
              mqaf_pkg::CMD_ADD: begin
                if (!qflags.full) begin
                  wr_idx_q[cur_idx] <= wr_next;
                  if (qflags.empty) begin
                    start_q[cur_idx] <= now_q;
                  end
                end
              end
              mqaf_pkg::CMD_NEXT: begin
                if (!qflags.empty) begin
                  rd_idx_q[cur_idx] <= rd_next;
                  if (!qflags.rd_next_empty) begin
                    start_q[cur_idx] <= now_q;
                  end
                end
              end
              mqaf_pkg::CMD_SET_ERROR: begin
                err_q[cur_idx] <= errv_q;
              end
              mqaf_pkg::CMD_RESET_ONE: begin
                wr_idx_q[cur_idx] <= '0;
                rd_idx_q[cur_idx] <= '0;
                err_q[cur_idx]    <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (ne_from_scan == '0) begin
            state_q <= ST_IDLE;
          end else if (ne_from_scan[0]) begin
            kind_q  <= mqaf_pkg::EV_RUN;
            qv_q    <= 1'b1;
            hv_q    <= 1'b1;
            acc_q   <= 1'b0;
            last_q  <= ((ne_from_scan >> 1) == '0);
            state_q <= ST_READ;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            ov_q       <= 1'b1;
            o_kind_q   <= kind_q;
            o_acc_q    <= acc_q;
            o_last_q   <= last_q;
            o_action_q <= head_on ? mem_rdata[EntryBits-1:ArgBits] : '0;
            o_arg_q    <= head_on ? mem_rdata[ArgBits-1:0] : '0;
            o_start_q  <= head_on ? start_q[cur_idx] : '0;
            o_err_q    <= qv_q ? err_q[cur_idx] : 1'b0;
            if (cmd_q == mqaf_pkg::CMD_RUN) begin
              o_queue_q <= SelBits'(scan_q);
            end else if (cmd_q == mqaf_pkg::CMD_RESET_ALL) begin
              o_queue_q <= '0;
            end else begin
              o_queue_q <= sel_q;
            end
            if (last_q || scan_q == LastQueue) begin
              state_q <= ST_IDLE;
            end else begin
              scan_q  <= scan_q + 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = o_kind_q;
  assign m_axis_tdata_o  = {{(mqaf_pkg::OUT_TDATA_BITS - OutUsed){1'b0}},
                            o_acc_q, o_err_q, o_start_q, o_arg_q, o_action_q, o_queue_q};

  `MQAF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "command taken while busy")
  `MQAF_ASSERT_IMPL(a_write_has_room, mem_we, sel_valid && !qflags.full, "entry written to a full or absent queue")
  `MQAF_ASSERT_NEXT(a_write_then_read, mem_we, state_q == ST_READ, "entry write not followed by head read")
  `MQAF_ASSERT_IMPL(a_index_range, (state_q == ST_EXEC) && sel_valid, (int'(wr_cur) < Slots) && (int'(rd_cur) < Slots), "queue index out of range")

endmodule

>>> sim/tb_multi_queue_action_fifo.sv
`timescale 1ns / 1ps

module tb_multi_queue_action_fifo;

  localparam int NQ = mqaf_pkg::NUM_QUEUES_DEF;
  localparam int SLOTS = mqaf_pkg::QUEUE_DEPTH_DEF + 1;
  localparam int SELW = mqaf_pkg::SEL_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS = 235;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [mqaf_pkg::CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [mqaf_pkg::CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [mqaf_pkg::CMD_BITS-1:0]    cmd;
    logic [mqaf_pkg::SEL_BITS-1:0]    sel;
    logic [mqaf_pkg::ACTION_BITS-1:0] code;
    logic [mqaf_pkg::ARG_BITS-1:0]    arg;
    logic [mqaf_pkg::TIME_BITS-1:0]   now_t;
    logic                             errv;
  } command_t;

  typedef struct packed {
    logic [mqaf_pkg::KIND_BITS-1:0]   kind;
    logic [mqaf_pkg::SEL_BITS-1:0]    qid;
    logic [mqaf_pkg::ACTION_BITS-1:0] action;
    logic [mqaf_pkg::ARG_BITS-1:0]    arg;
    logic [mqaf_pkg::TIME_BITS-1:0]   stime;
    logic                             errf;
    logic                             acc;
    logic                             last;
  } head_event_t;

  typedef struct packed {
    command_t    c;
    logic        typed;
    head_event_t ev;
  } dir_row_t;

  localparam head_event_t NO_EV = '0;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic [mqaf_pkg::IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [mqaf_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  logic [mqaf_pkg::KIND_BITS-1:0]      m_tuser;
  logic                                m_tlast;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;

  // predicted queue contents
  logic [mqaf_pkg::ACTION_BITS-1:0] act_mem [NQ][SLOTS];
  logic [mqaf_pkg::ARG_BITS-1:0]    arg_mem [NQ][SLOTS];
  logic [3:0]                       wr_ptr [NQ];
  logic [3:0]                       rd_ptr [NQ];
  logic [mqaf_pkg::TIME_BITS-1:0]   t_start [NQ];
  logic                             err_q [NQ];

  head_event_t pending_events [$];
  int n_items = 0;
  int n_beats = 0;
  int n_refused = 0;
  int n_errors = 0;
  int cycles = 0;
  int stall_cnt = 0;
  int stall_mode = 0;
  int hot_q = 0;

  multi_queue_action_fifo u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] wrap_inc(logic [3:0] p);
    return (p == SLOTS - 1) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic head_event_t head_of(logic [mqaf_pkg::KIND_BITS-1:0] kind, int q,
                                          logic acc);
    head_event_t e;
    e = '0;
    e.kind = kind;
    e.qid = SELW'(q);
    if (wr_ptr[q] != rd_ptr[q]) begin
      e.action = act_mem[q][rd_ptr[q]];
      e.arg = arg_mem[q][rd_ptr[q]];
      e.stime = t_start[q];
    end
    e.errf = err_q[q];
    e.acc = acc;
    return e;
  endfunction

  // updates the queue state and, when keep is set, queues the beats the command causes
  function automatic void queue_update(command_t c, bit keep);
    head_event_t evs [$];
    int q;
    int i;
    bit was_empty;
    q = int'(c.sel);
    case (c.cmd)
      mqaf_pkg::CMD_RUN: begin
        for (i = 0; i < NQ; i++)
          if (wr_ptr[i] != rd_ptr[i]) evs.push_back(head_of(mqaf_pkg::EV_RUN, i, 1'b0));
      end
      mqaf_pkg::CMD_RESET_ALL: begin
        for (i = 0; i < NQ; i++) begin
          wr_ptr[i] = '0;
          rd_ptr[i] = '0;
          err_q[i] = 1'b0;
        end
        evs.push_back(NO_EV);
      end
      mqaf_pkg::CMD_ADD: begin
        if (wrap_inc(wr_ptr[q]) == rd_ptr[q]) begin
          n_refused++;
          evs.push_back(head_of(mqaf_pkg::EV_STATUS, q, 1'b0));
        end else begin
          was_empty = (wr_ptr[q] == rd_ptr[q]);
          act_mem[q][wr_ptr[q]] = c.code;
          arg_mem[q][wr_ptr[q]] = c.arg;
          wr_ptr[q] = wrap_inc(wr_ptr[q]);
          if (was_empty) t_start[q] = c.now_t;
          evs.push_back(head_of(was_empty ? mqaf_pkg::EV_START : mqaf_pkg::EV_STATUS,
                                q, 1'b1));
        end
      end
      mqaf_pkg::CMD_NEXT: begin
        if (wr_ptr[q] == rd_ptr[q]) begin
          evs.push_back(head_of(mqaf_pkg::EV_STATUS, q, 1'b0));
        end else begin
          rd_ptr[q] = wrap_inc(rd_ptr[q]);
          if (wr_ptr[q] != rd_ptr[q]) begin
            t_start[q] = c.now_t;
            evs.push_back(head_of(mqaf_pkg::EV_START, q, 1'b0));
          end else begin
            evs.push_back(head_of(mqaf_pkg::EV_STATUS, q, 1'b0));
          end
        end
      end
      mqaf_pkg::CMD_SET_ERROR: begin
        err_q[q] = c.errv;
        evs.push_back(head_of(mqaf_pkg::EV_STATUS, q, 1'b0));
      end
      mqaf_pkg::CMD_RESET_ONE: begin
        wr_ptr[q] = '0;
        rd_ptr[q] = '0;
        err_q[q] = 1'b0;
        evs.push_back(head_of(mqaf_pkg::EV_STATUS, q, 1'b0));
      end
      default: evs.push_back(head_of(mqaf_pkg::EV_STATUS, q, 1'b0));
    endcase
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    if (keep)
      foreach (evs[k]) pending_events.push_back(evs[k]);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic command_t random_command();
    command_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 44) c.cmd = mqaf_pkg::CMD_ADD;
    else if (r < 70) c.cmd = mqaf_pkg::CMD_NEXT;
    else if (r < 80) c.cmd = mqaf_pkg::CMD_RUN;
    else if (r < 88) c.cmd = mqaf_pkg::CMD_SET_ERROR;
    else if (r < 93) c.cmd = mqaf_pkg::CMD_RESET_ONE;
    else if (r < 96) c.cmd = mqaf_pkg::CMD_RESET_ALL;
    else if (r < 98) c.cmd = CMD_SPARE6;
    else c.cmd = CMD_SPARE7;
    c.sel = ($urandom_range(0, 2) == 0) ? SELW'($urandom_range(0, NQ - 1)) : SELW'(hot_q);
    c.code = mqaf_pkg::ACTION_BITS'($urandom_range(0, 255));
    c.arg = pick_word();
    c.now_t = pick_word();
    c.errv = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_command(command_t c, logic typed, head_event_t ev);
    s_tdata <= {2'b00, c.errv, c.now_t, c.arg, c.code, c.sel, c.cmd};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    n_items++;
    queue_update(c, !typed);
    if (typed) pending_events.push_back(ev);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // result side
  always @(posedge clk_i) begin
    head_event_t e;
    if (m_tvalid && m_tready) begin
      n_beats++;
      if (pending_events.size() == 0) begin
        $error("result beat with nothing pending: tuser %h tdata %h", m_tuser, m_tdata);
        n_errors++;
      end else begin
        e = pending_events.pop_front();
        check_field("event_kind", 32'(e.kind), 32'(m_tuser));
        check_field("event_queue", 32'(e.qid), 32'(m_tdata[1:0]));
        check_field("head_action", 32'(e.action), 32'(m_tdata[9:2]));
        check_field("head_arg", e.arg, m_tdata[41:10]);
        check_field("head_start_time", e.stime, m_tdata[73:42]);
        check_field("error_flag", 32'(e.errf), 32'(m_tdata[74]));
        check_field("accepted", 32'(e.acc), 32'(m_tdata[75]));
        check_field("last", 32'(e.last), 32'(m_tlast));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt <= $urandom_range(16, 80);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (cycles % 8) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_events.size());
      $display("** multi_queue_action_fifo: FAILED **");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    command_t c;
    int k;
    int burst;
    int gap;

    foreach (wr_ptr[i]) begin
      wr_ptr[i] = '0;
      rd_ptr[i] = '0;
      t_start[i] = '0;
      err_q[i] = 1'b0;
    end

    dir_tab = '{
      '{'{mqaf_pkg::CMD_RUN, 2'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_NEXT, 2'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1,
        '{mqaf_pkg::EV_STATUS, 2'd0, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b1,
        '{mqaf_pkg::EV_START, 2'd0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1}},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h00, 32'h0, 32'h5, 1'b1}, 1'b1,
        '{mqaf_pkg::EV_STATUS, 2'd0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1}},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h01, 32'h1111_0001, 32'h10, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h02, 32'h2222_0002, 32'h11, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h04, 32'h4444_0004, 32'h12, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h08, 32'h8888_0008, 32'h13, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h10, 32'h0F0F_0F0F, 32'h14, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h20, 32'hF0F0_F0F0, 32'h15, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd0, 8'h40, 32'hDEAD_BEEF, 32'h16, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_SET_ERROR, 2'd0, 8'h00, 32'h0, 32'h0, 1'b1}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_SET_ERROR, 2'd1, 8'h00, 32'h0, 32'h0, 1'b1}, 1'b1,
        '{mqaf_pkg::EV_STATUS, 2'd1, 8'h00, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1}},
      '{'{mqaf_pkg::CMD_ADD, 2'd1, 8'hA5, 32'h1234_5678, 32'h100, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd2, 8'h5A, 32'h8765_4321, 32'h200, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_ADD, 2'd3, 8'h80, 32'h8000_0000, 32'h300, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_RUN, 2'd3, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_NEXT, 2'd0, 8'h00, 32'h0, 32'h400, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_NEXT, 2'd1, 8'h00, 32'h0, 32'h500, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_SET_ERROR, 2'd1, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, NO_EV},
      '{'{CMD_SPARE6, 2'd2, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_EV},
      '{'{CMD_SPARE7, 2'd3, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, NO_EV},
      '{'{mqaf_pkg::CMD_RESET_ONE, 2'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1,
        '{mqaf_pkg::EV_STATUS, 2'd0, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
      '{'{mqaf_pkg::CMD_RESET_ALL, 2'd2, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1,
        '{mqaf_pkg::EV_STATUS, 2'd0, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
      '{'{mqaf_pkg::CMD_RUN, 2'd1, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, NO_EV}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_command(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].ev);
    wait_all_results();

    burst = 0;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 40 == 0) hot_q = $urandom_range(0, NQ - 1);
      if (k == RAND_ITEMS / 2) begin
        wait_all_results();
        burst = 0;
      end
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 12);
      end
      c = random_command();
      send_command(c, 1'b0, NO_EV);
      burst--;
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d commands (%0d refused adds), checked %0d result beats, %0d mismatches",
             n_items, n_refused, n_beats, n_errors);
    if (n_errors == 0 && pending_events.size() == 0) begin
      $display("** multi_queue_action_fifo: PASSED **");
    end else begin
      $display("** multi_queue_action_fifo: FAILED **");
    end
    $finish;
  end

endmodule
